>>> hdl/touch_report_scan_filter_defines.svh
// assertion macros used by the touch report scan filter checker
`ifndef TOUCH_REPORT_SCAN_FILTER_DEFINES_SVH
`define TOUCH_REPORT_SCAN_FILTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TRSF_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TRSF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/trsf_pkg.sv
// types, constants and helpers for the touch report scan filter
package trsf_pkg;

    typedef logic [4:0][31:0] point_arr_t;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_ORIENTATION   = 2'd0;
    localparam cfg_index_t CFG_SCREEN_WIDTH  = 2'd1;
    localparam cfg_index_t CFG_SCREEN_HEIGHT = 2'd2;

    localparam logic [1:0] ORIENT_VERTICAL   = 2'd0;
    localparam logic [1:0] ORIENT_HORIZONTAL = 2'd1;

    localparam logic [1:0]  ORIENT_RESET = ORIENT_VERTICAL;
    localparam logic [15:0] WIDTH_RESET  = 16'd480;
    localparam logic [15:0] HEIGHT_RESET = 16'd800;

    localparam logic [7:0]  PRESSED_BIT       = 8'h80;
    localparam logic [7:0]  CAPTURED_BIT      = 8'h40;
    localparam logic [7:0]  RELEASE_KEEP_MASK = 8'hE0;
    localparam logic [31:0] RELEASED_POINT    = 32'hFFFF_FFFF;

    localparam logic [7:0] POLL_PERIOD     = 8'd10;
    localparam logic [7:0] TICK_WRAP_LIMIT = 8'd240;
    localparam logic [7:0] TICK_RESTART    = 8'd10;

    typedef struct packed {
        logic [1:0]  orientation;
        logic [15:0] screen_width;
        logic [15:0] screen_height;
    } cfg_t;

    typedef struct packed {
        logic polled;
        logic new_data;
        logic clear_status;
    } step_status_t;

    // t mod 10 by reciprocal multiply, exact for all 8-bit values
    function automatic logic poll_tick(input logic [7:0] t);
        logic [15:0] prod;
        logic [7:0]  quot;
        logic [7:0]  rem;
        prod = 16'(t) * 16'd205;
        quot = 8'(prod >> 11);
        rem  = t - 8'(quot * POLL_PERIOD);
        return (rem == 8'd0) || (t < POLL_PERIOD);
    endfunction

endpackage

>>> hdl/trsf_step.sv
// next-state and status logic for one scan tick
module trsf_step #(
    parameter int NUM_POINTS = 5
) (
    input  logic [7:0]              tick_count,
    input  logic [7:0]              flags,
    input  trsf_pkg::point_arr_t    points,
    input  logic [7:0]              status_byte,
    input  trsf_pkg::point_arr_t    raw_points,
    input  trsf_pkg::cfg_t          cfg,
    output logic [7:0]              tick_next,
    output logic [7:0]              flags_next,
    output trsf_pkg::point_arr_t    points_next,
    output trsf_pkg::step_status_t  status
);

    localparam logic [3:0] MAX_COUNT = 4'(NUM_POINTS);

    logic [7:0]           tick_inc;
    logic                 polled;
    logic [3:0]           cnt;
    logic                 cnt_ok;
    logic                 accept_cnt;
    logic [4:0]           active;
    trsf_pkg::point_arr_t upd;
    logic                 off_screen;
    logic                 undone;
    logic                 release_now;
    logic [7:0]           flag_mid;
    logic [31:0]          p0_mid;
    logic [7:0]           tick_work;

    assign tick_inc   = tick_count + 8'd1;
    assign polled     = trsf_pkg::poll_tick(tick_inc);
    assign cnt        = polled ? status_byte[3:0] : 4'd0;
    assign cnt_ok     = cnt <= MAX_COUNT;
    assign accept_cnt = polled && (cnt != 4'd0) && cnt_ok;

    // per-point conversion, slot 4 starts from the previous point 0
    always_comb
    begin
        logic [31:0] base;
        logic [31:0] raw;
        for (int i = 0; i < 5; i++)
        begin
            active[i] = 4'(i) < cnt;
            base      = (i == 4) ? points[0] : points[i];
            raw       = raw_points[i];
            if (!accept_cnt)
            begin
                upd[i] = points[i];
            end
            else if (!active[i])
            begin
                upd[i] = base;
            end
            else if (cfg.orientation == trsf_pkg::ORIENT_VERTICAL)
            begin
                upd[i] = raw;
            end
            else if (cfg.orientation == trsf_pkg::ORIENT_HORIZONTAL)
            begin
                upd[i] = {raw[15:0], cfg.screen_width - raw[31:16]};
            end
            else
            begin
                upd[i] = base;
            end
        end
    end

    assign off_screen = accept_cnt &&
                        ((upd[0][15:0] > cfg.screen_width) ||
                         (upd[0][31:16] > cfg.screen_height));
    assign undone     = off_screen && (cnt == 4'd1);

    always_comb
    begin
        priority if (off_screen && !undone)
        begin
            p0_mid = upd[1];
        end
        else if (undone)
        begin
            p0_mid = upd[4];
        end
        else
        begin
            p0_mid = upd[0];
        end
    end

    // undone poll keeps the previous flags
    assign flag_mid = (accept_cnt && !undone)
                    ? (trsf_pkg::PRESSED_BIT | trsf_pkg::CAPTURED_BIT | {3'b000, active})
                    : flags;

    assign release_now = undone ||
                         (polled && status_byte[7] && (status_byte[3:0] == 4'd0));

    always_comb
    begin
        points_next    = upd;
        points_next[0] = p0_mid;
        flags_next     = flag_mid;
        if (release_now)
        begin
            if (flag_mid[7])
            begin
                flags_next = flag_mid & ~trsf_pkg::PRESSED_BIT;
            end
            else
            begin
                points_next[0] = trsf_pkg::RELEASED_POINT;
                flags_next     = flag_mid & trsf_pkg::RELEASE_KEEP_MASK;
            end
        end
    end

    assign tick_work = (accept_cnt && !undone) ? 8'd0 : tick_inc;
    assign tick_next = (tick_work > trsf_pkg::TICK_WRAP_LIMIT) ? trsf_pkg::TICK_RESTART
                                                               : tick_work;

    assign status.polled       = polled;
    assign status.new_data     = accept_cnt;
    assign status.clear_status = polled && status_byte[7] && cnt_ok;

endmodule

>>> hdl/touch_report_scan_filter.sv
// top level of the touch report scan filter
//
// one input beat is one scan tick: the controller status byte and five raw
// point records. each accepted tick yields exactly one output beat with the
// poll, new data and clear-status indications, the flag byte and the five
// stored points after that tick.
// the input channel accepts a beat when in_valid is high and in_stall low;
// the output channel hands a beat over when out_valid is high and out_stall low.
// a tick passes through the input register and is then computed into the
// state and status registers. throughput is one tick per cycle while out_stall
// is low, with a single compute stage between those registers.
// while the receiver stalls, the output beat holds and the input register
// keeps its beat; in_stall rises once both are full.
// configuration writes go over cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high. the user must make writes only while no tick is in flight;
// the block does not enforce this. reset clears the tick counter, flags and
// points, and loads orientation vertical, width 480 and height 800.
module touch_report_scan_filter #(
    parameter int NUM_POINTS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  status_byte,
    input  logic [31:0] raw_point0,
    input  logic [31:0] raw_point1,
    input  logic [31:0] raw_point2,
    input  logic [31:0] raw_point3,
    input  logic [31:0] raw_point4,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        polled,
    output logic        new_data,
    output logic        clear_status,
    output logic [7:0]  touch_flags,
    output logic [31:0] point0,
    output logic [31:0] point1,
    output logic [31:0] point2,
    output logic [31:0] point3,
    output logic [31:0] point4,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic                    in_valid_reg;
    logic [7:0]              status_reg;
    trsf_pkg::point_arr_t    raw_reg;
    logic                    out_valid_reg;
    trsf_pkg::step_status_t  out_status_reg;
    logic [7:0]              tick_reg;
    logic [7:0]              flag_reg;
    trsf_pkg::point_arr_t    point_reg;
    trsf_pkg::cfg_t          cfg_reg;

    logic                    advance;
    logic                    in_take;
    logic [7:0]              tick_next;
    logic [7:0]              flag_next;
    trsf_pkg::point_arr_t    point_next;
    trsf_pkg::step_status_t  status_next;

    assign cfg_ready = 1'b1;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.orientation   <= trsf_pkg::ORIENT_RESET;
            cfg_reg.screen_width  <= trsf_pkg::WIDTH_RESET;
            cfg_reg.screen_height <= trsf_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                trsf_pkg::CFG_ORIENTATION:   cfg_reg.orientation   <= cfg_data[1:0];
                trsf_pkg::CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data;
                trsf_pkg::CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            status_reg <= status_byte;
            raw_reg    <= {raw_point4, raw_point3, raw_point2, raw_point1, raw_point0};
        end
    end

    trsf_step #(
        .NUM_POINTS (NUM_POINTS)
    ) u_step (
        .tick_count  (tick_reg),
        .flags       (flag_reg),
        .points      (point_reg),
        .status_byte (status_reg),
        .raw_points  (raw_reg),
        .cfg         (cfg_reg),
        .tick_next   (tick_next),
        .flags_next  (flag_next),
        .points_next (point_next),
        .status      (status_next)
    );

    // state doubles as the output beat: it only moves when the output is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            tick_reg       <= 8'd0;
            flag_reg       <= 8'd0;
            point_reg      <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                out_status_reg <= status_next;
                tick_reg       <= tick_next;
                flag_reg       <= flag_next;
                point_reg      <= point_next;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign polled       = out_status_reg.polled;
    assign new_data     = out_status_reg.new_data;
    assign clear_status = out_status_reg.clear_status;
    assign touch_flags  = flag_reg;
    assign point0       = point_reg[0];
    assign point1       = point_reg[1];
    assign point2       = point_reg[2];
    assign point3       = point_reg[3];
    assign point4       = point_reg[4];

endmodule

>>> hdl/trsf_checker.sv
// port-level checks for the touch report scan filter, bound to the top level
`include "touch_report_scan_filter_defines.svh"

module trsf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        polled,
    input logic        new_data,
    input logic        clear_status,
    input logic [7:0]  touch_flags,
    input logic [31:0] point0,
    input logic [31:0] point1,
    input logic [31:0] point2,
    input logic [31:0] point3,
    input logic [31:0] point4
);

    logic [170:0] out_beat;

    assign out_beat = {polled, new_data, clear_status, touch_flags,
                       point4, point3, point2, point1, point0};

    // a stalled output beat holds
    `TRSF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat), "stalled output beat changed")

    // new data only comes from a polling tick
    `TRSF_ASSERT_NOW(a_new_needs_poll, out_valid && new_data, polled, "new_data without poll")

    // a status clear only comes from a polling tick
    `TRSF_ASSERT_NOW(a_clear_needs_poll, out_valid && clear_status, polled, "clear_status without poll")

    // the input side only backs up behind a full, stalled output
    `TRSF_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with output free")

endmodule

bind touch_report_scan_filter trsf_checker u_trsf_checker (.*);

>>> tb/tb_touch_report_scan_filter.sv
// self-checking testbench for touch_report_scan_filter: predicts every scan tick and compares beats
module tb_touch_report_scan_filter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_POINTS       = 5;
    localparam int          LONG_HOLD_CYCLES = 60;
    localparam int unsigned CYCLE_LIMIT      = 1_000_000;

    localparam logic [1:0] ORIENT_KEEP     = 2'd2;
    localparam logic [1:0] ORIENT_KEEP_ALT = 2'd3;

    localparam logic [7:0] STATUS_READY       = 8'h80;
    localparam logic [7:0] RELEASE_MATCH_MASK = 8'h8F;
    localparam logic [7:0] PRESSED_CLEAR_MASK = 8'h7F;

    typedef enum {TICK_TOUCH, TICK_RELEASE, TICK_NOISE, TICK_QUIET} tick_kind_t;

    typedef struct packed {
        logic                 polled;
        logic                 new_data;
        logic                 clear_status;
        logic [7:0]           flags;
        trsf_pkg::point_arr_t points;
    } tick_report_t;

    // keeps its own copy of the filter state and the reports still owed
    class tick_report_board;
        logic [1:0]           orient;
        logic [15:0]          width;
        logic [15:0]          height;
        logic [7:0]           ticks;
        logic [7:0]           flags;
        trsf_pkg::point_arr_t points;
        tick_report_t         pending[$];
        int                   errors;

        function new();
            orient = trsf_pkg::ORIENT_RESET;
            width  = trsf_pkg::WIDTH_RESET;
            height = trsf_pkg::HEIGHT_RESET;
            ticks  = '0;
            flags  = '0;
            points = '0;
            errors = 0;
        endfunction

        function void set_cfg(trsf_pkg::cfg_index_t idx, logic [15:0] data);
            case (idx)
                trsf_pkg::CFG_ORIENTATION:   orient = data[1:0];
                trsf_pkg::CFG_SCREEN_WIDTH:  width  = data;
                trsf_pkg::CFG_SCREEN_HEIGHT: height = data;
                default: ;
            endcase
        endfunction

        // returns whether the tick polled
        function bit predict_tick(logic [7:0] status, trsf_pkg::point_arr_t raw);
            tick_report_t r;
            logic [7:0]   mode;
            logic [7:0]   saved;
            logic [7:0]   mask;
            logic [3:0]   cnt;
            logic [15:0]  a;
            logic [15:0]  b;
            mode           = '0;
            r.new_data     = 1'b0;
            r.clear_status = 1'b0;
            ticks          = ticks + 8'd1;
            r.polled       = (ticks % trsf_pkg::POLL_PERIOD == 8'd0) ||
                             (ticks < trsf_pkg::POLL_PERIOD);
            if (r.polled)
            begin
                mode           = status;
                cnt            = mode[3:0];
                r.clear_status = mode[7] && (cnt <= MAX_POINTS);
                if (cnt != 4'd0 && cnt <= MAX_POINTS)
                begin
                    saved     = flags;
                    mask      = 8'hFF << cnt;
                    flags     = ~mask | trsf_pkg::PRESSED_BIT | trsf_pkg::CAPTURED_BIT;
                    points[4] = points[0];
                    for (int i = 0; i < MAX_POINTS; i++)
                    begin
                        a = raw[i][15:0];
                        b = raw[i][31:16];
                        if (flags[i] && orient == trsf_pkg::ORIENT_VERTICAL)
                            points[i] = {b, a};
                        else if (flags[i] && orient == trsf_pkg::ORIENT_HORIZONTAL)
                            points[i] = {a, 16'(width - b)};
                    end
                    r.new_data = 1'b1;
                    // first point off the screen: fall back to point 1 or undo the poll
                    if (points[0][15:0] > width || points[0][31:16] > height)
                    begin
                        if (cnt > 4'd1)
                        begin
                            points[0] = points[1];
                            ticks     = '0;
                        end
                        else
                        begin
                            points[0] = points[4];
                            mode      = STATUS_READY;
                            flags     = saved;
                        end
                    end
                    else
                        ticks = '0;
                end
            end
            if ((mode & RELEASE_MATCH_MASK) == STATUS_READY)
            begin
                if (flags & trsf_pkg::PRESSED_BIT)
                    flags = flags & PRESSED_CLEAR_MASK;
                else
                begin
                    points[0] = trsf_pkg::RELEASED_POINT;
                    flags     = flags & trsf_pkg::RELEASE_KEEP_MASK;
                end
            end
            if (ticks > trsf_pkg::TICK_WRAP_LIMIT)
                ticks = trsf_pkg::TICK_RESTART;
            r.flags  = flags;
            r.points = points;
            pending.push_back(r);
            return r.polled;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_report(tick_report_t got);
            tick_report_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("output beat with no tick pending");
                return;
            end
            want = pending.pop_front();
            if (got.polled !== want.polled)
                report_mismatch($sformatf("polled expected %0b got %0b",
                                          want.polled, got.polled));
            if (got.new_data !== want.new_data)
                report_mismatch($sformatf("new_data expected %0b got %0b",
                                          want.new_data, got.new_data));
            if (got.clear_status !== want.clear_status)
                report_mismatch($sformatf("clear_status expected %0b got %0b",
                                          want.clear_status, got.clear_status));
            if (got.flags !== want.flags)
                report_mismatch($sformatf("touch_flags expected %h got %h",
                                          want.flags, got.flags));
            for (int i = 0; i < MAX_POINTS; i++)
                if (got.points[i] !== want.points[i])
                    report_mismatch($sformatf("point%0d expected %h got %h",
                                              i, want.points[i], got.points[i]));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [7:0]           status_byte  = '0;
    logic [31:0]          raw_point0   = '0;
    logic [31:0]          raw_point1   = '0;
    logic [31:0]          raw_point2   = '0;
    logic [31:0]          raw_point3   = '0;
    logic [31:0]          raw_point4   = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic                 polled;
    logic                 new_data;
    logic                 clear_status;
    logic [7:0]           touch_flags;
    logic [31:0]          point0;
    logic [31:0]          point1;
    logic [31:0]          point2;
    logic [31:0]          point3;
    logic [31:0]          point4;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    trsf_pkg::cfg_index_t cfg_index    = trsf_pkg::CFG_ORIENTATION;
    logic [15:0]          cfg_data     = '0;

    tick_report_board sb;
    int unsigned      polled_ticks = 0;
    int unsigned      tx_idle_odds = 3;
    bit               calm         = 1'b0;
    bit               long_hold    = 1'b0;

    touch_report_scan_filter dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin : result_monitor
        tick_report_t got;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            got.polled       = polled;
            got.new_data     = new_data;
            got.clear_status = clear_status;
            got.flags        = touch_flags;
            got.points       = {point4, point3, point2, point1, point0};
            sb.check_report(got);
        end
    end

    // output side: random stall bursts, one long hold on request
    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                long_hold = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                n = $urandom_range(1, 14);
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
                n = $urandom_range(0, 25);
                repeat (n) @(posedge clk);
            end
        end
    end

    function automatic logic [15:0] pick_coord(logic [15:0] lim);
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return lim;
            default: return 16'($urandom_range(0, lim));
        endcase
    endfunction

    // a raw record that lands on or off the screen for the current orientation
    function automatic logic [31:0] make_point(bit on_screen);
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] alim;
        logic [15:0] blim;
        if (sb.orient == trsf_pkg::ORIENT_HORIZONTAL)
        begin
            alim = sb.height;
            blim = sb.width;
        end
        else
        begin
            alim = sb.width;
            blim = sb.height;
        end
        a = pick_coord(alim);
        b = pick_coord(blim);
        if (!on_screen)
        begin
            if (alim != 16'hFFFF && (blim == 16'hFFFF || $urandom_range(0, 1) == 0))
                a = 16'($urandom_range(alim + 1, 16'hFFFF));
            else if (blim != 16'hFFFF)
                b = 16'($urandom_range(blim + 1, 16'hFFFF));
            else
                return $urandom();
        end
        return {b, a};
    endfunction

    function automatic void make_tick(tick_kind_t kind, output logic [7:0] st,
                                      output trsf_pkg::point_arr_t raw);
        for (int i = 0; i < MAX_POINTS; i++)
            raw[i] = $urandom();
        case (kind)
            TICK_TOUCH:
            begin
                st = {1'($urandom_range(0, 4) != 0), 3'($urandom_range(0, 7)),
                      4'($urandom_range(1, MAX_POINTS))};
                raw[0] = make_point($urandom_range(0, 9) != 0);
                for (int i = 1; i < MAX_POINTS; i++)
                    if ($urandom_range(0, 4) != 0)
                        raw[i] = make_point(1'b1);
            end
            TICK_RELEASE:
                st = {1'($urandom_range(0, 4) != 0), 3'($urandom_range(0, 7)), 4'h0};
            TICK_NOISE:
                st = 8'($urandom_range(0, 255));
            default:
            begin
                // no usable touch count, so no poll ever clears the counter
                st = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 0)
                    st[3:0] = 4'h0;
                else if (st[3:0] != 4'h0 && st[3:0] <= MAX_POINTS)
                    st[3:0] = 4'($urandom_range(MAX_POINTS + 1, 15));
            end
        endcase
    endfunction

    task automatic send_tick(logic [7:0] st, trsf_pkg::point_arr_t raw);
        if (!calm && $urandom_range(0, 9) < tx_idle_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        status_byte <= st;
        raw_point0  <= raw[0];
        raw_point1  <= raw[1];
        raw_point2  <= raw[2];
        raw_point3  <= raw[3];
        raw_point4  <= raw[4];
        do
            @(posedge clk);
        while (in_stall);
        if (sb.predict_tick(st, raw))
            polled_ticks++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    task automatic load_config(logic [1:0] orient, logic [15:0] width, logic [15:0] height);
        trsf_pkg::cfg_index_t regs[3] = '{trsf_pkg::CFG_ORIENTATION,
                                          trsf_pkg::CFG_SCREEN_WIDTH,
                                          trsf_pkg::CFG_SCREEN_HEIGHT};
        logic [15:0]          vals[3] = '{16'(orient), width, height};
        drain_results();
        repeat (4) @(posedge clk);
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.set_cfg(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] xy(logic [15:0] x, logic [15:0] y);
        return {y, x};
    endfunction

    // runs on the reset screen of 480 by 800, vertical
    task automatic directed_ticks();
        send_tick(8'h81, {32'h0, 32'h0, 32'h0, 32'h0, xy(200, 100)});
        send_tick(8'h85, {xy(100, 100), xy(479, 799), xy(1, 2), xy(480, 800), xy(0, 0)});
        send_tick(8'h05, '0);
        // off-screen first point, more than one active: falls back to point 1
        send_tick(8'h82, {32'h0, 32'h0, 32'h0, xy(30, 40), xy(481, 10)});
        send_tick(8'h83, {32'h0, 32'h0, xy(7, 8), xy(50, 60), xy(5, 801)});
        // off-screen with a single point: poll undone, pressed cleared
        send_tick(8'h01, {5{32'hFFFF_FFFF}});
        // release with pressed already clear marks point 0
        send_tick(8'h80, {5{32'h1234_5678}});
        send_tick(8'hF0, '0);
        send_tick(8'h00, {5{32'hFFFF_FFFF}});
        send_tick(8'h8F, {5{32'h0001_0001}});
        send_tick(8'h86, {5{32'h0002_0002}});
        send_tick(8'hFF, {5{32'hFFFF_FFFF}});
        send_tick(8'h84, {xy(9, 9), xy(480, 0), xy(0, 800), xy(480, 800), xy(240, 400)});
        send_tick(8'h02, {32'h0, 32'h0, 32'h0, xy(11, 22), xy(33, 44)});
        // idle ticks carry the counter past the polling window
        repeat (11) send_tick(8'h00, {5{32'hFFFF_FFFF}});
        send_tick(8'h81, {5{32'h0010_0010}});
    endtask

    task automatic run_phase(int unsigned target, int unsigned quiet_len);
        int unsigned          start;
        int unsigned          pick;
        logic [7:0]           st;
        trsf_pkg::point_arr_t raw;
        tx_idle_odds = $urandom_range(0, 4);
        repeat (quiet_len)
        begin
            make_tick(TICK_QUIET, st, raw);
            send_tick(st, raw);
        end
        start = polled_ticks;
        while (polled_ticks - start < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                make_tick(TICK_TOUCH, st, raw);
            else if (pick < 82)
                make_tick(TICK_RELEASE, st, raw);
            else
                make_tick(TICK_NOISE, st, raw);
            send_tick(st, raw);
        end
    endtask

    initial
    begin : stimulus
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_ticks();
        run_phase(100, 0);

        load_config(trsf_pkg::ORIENT_HORIZONTAL, 16'd480, 16'd800);
        long_hold = 1'b1;
        run_phase(90, 0);

        load_config(ORIENT_KEEP, 16'd1024, 16'd600);
        run_phase(80, 300);

        load_config(trsf_pkg::ORIENT_VERTICAL, 16'hFFFF, 16'hFFFF);
        run_phase(40, 0);
        drain_results();
        run_phase(40, 0);

        load_config(trsf_pkg::ORIENT_HORIZONTAL, 16'd0, 16'd0);
        run_phase(80, 0);

        load_config(ORIENT_KEEP_ALT, 16'd320, 16'd240);
        run_phase(70, 0);

        load_config(trsf_pkg::ORIENT_VERTICAL, 16'd0, 16'hFFFF);
        run_phase(80, 0);

        load_config(trsf_pkg::ORIENT_HORIZONTAL, 16'hFFFF, 16'd0);
        run_phase(80, 0);

        calm = 1'b1;
        load_config(trsf_pkg::ORIENT_VERTICAL, 16'd800, 16'd480);
        run_phase(120, 0);

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
